>>> design/hll_pkg.sv
// Shared types and constants for the cardinality-sketch register update block.
// Used by hll_front, hll_back and hyperloglog_register_update_top.
package hll_pkg;

  localparam int HASH_W      = 32;
  localparam int KEY_W       = 32;
  localparam int SEED_COUNT  = 32;
  localparam int SEED_AW     = 5;
  localparam int RANK_W      = 6;
  localparam int MODE_W      = 2;
  localparam int CFG_W       = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] BUCKET_BITS_RST = 4'd10;

  // Item kinds as they arrive on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 2'd0,
    MODE_SEED   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  // Work the back end carries out for one item
  typedef enum logic [1:0] {
    OP_NONE,
    OP_UPDATE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [RANK_W-1:0] rank;
  } job_t;

endpackage

>>> design/hll_front.sv
// Front end: takes input items, holds the seed table, hashes keys and classifies items.
// Depends on hll_pkg; feeds jobs into hll_fifo.
module hll_front #(
  parameter int IW = 10,
  parameter int BW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hll_pkg::mode_e             mode_i,
  input  logic [hll_pkg::KEY_W-1:0]  key_i,
  input  logic [IW-1:0]              slot_i,
  input  logic [hll_pkg::HASH_W-1:0] seed_i,
  input  logic [BW-1:0]              bucket_bits_i,
  input  logic                       hold_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output hll_pkg::job_t              push_job_o,
  output logic [IW-1:0]              push_idx_o
);

  localparam int HW = hll_pkg::HASH_W;
  localparam int RW = hll_pkg::RANK_W;

  // Leading zeros of one byte, 8 when the byte is zero
  function automatic logic [3:0] lzc8(input logic [7:0] v);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zeros of a 32-bit word, built from byte counts
  function automatic logic [RW-1:0] lzc32(input logic [HW-1:0] v);
    logic [RW-1:0] n;
    priority if (v[31:24] != '0) begin
      n = RW'(lzc8(v[31:24]));
    end else if (v[23:16] != '0) begin
      n = RW'(8) + RW'(lzc8(v[23:16]));
    end else if (v[15:8] != '0) begin
      n = RW'(16) + RW'(lzc8(v[15:8]));
    end else begin
      n = RW'(24) + RW'(lzc8(v[7:0]));
    end
    return n;
  endfunction

  logic                         accept;
  logic                         seed_we;
  logic [hll_pkg::SEED_AW-1:0]  seed_sel;
  logic [HW-1:0]                seed_q [hll_pkg::SEED_COUNT];

  logic [HW-1:0] lv0 [32];
  logic [HW-1:0] lv1 [16];
  logic [HW-1:0] lv2 [8];
  logic [HW-1:0] lv3 [4];
  logic [HW-1:0] lv4 [2];
  logic [HW-1:0] hash;

  logic           f1_valid_q;
  hll_pkg::mode_e f1_mode_q;
  logic [HW-1:0]  f1_hash_q;
  logic [IW-1:0]  f1_slot_q;
  logic           f1_adv;
  logic           f1_free;

  logic           f2_valid_q;
  hll_pkg::op_e   f2_op_q;
  logic [IW-1:0]  f2_idx_q;
  logic [HW-1:0]  f2_rest_q;
  logic           f2_adv;
  logic           f2_free;

  hll_pkg::op_e   f2_op_d;
  logic [IW-1:0]  f2_idx_d;
  logic [HW-1:0]  f2_rest_d;
  logic [IW-1:0]  top_bits;
  logic [IW-1:0]  idx_mask;
  logic [BW-1:0]  shamt;

  logic [RW-1:0]  zeros;
  logic [RW-1:0]  rank;

  // Handshake and pipeline flow
  assign f2_adv     = f2_valid_q && push_ready_i;
  assign f2_free    = !f2_valid_q || f2_adv;
  assign f1_adv     = f1_valid_q && f2_free;
  assign f1_free    = !f1_valid_q || f1_adv;
  assign in_ready_o = f1_free && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  // Load seed words; an index past the table writes nothing
  assign seed_sel = hll_pkg::SEED_AW'(slot_i);
  assign seed_we  = accept && (mode_i == hll_pkg::MODE_SEED) &&
                    (32'(slot_i) < 32'(hll_pkg::SEED_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hll_pkg::SEED_COUNT; i++) begin
        seed_q[i] <= '0;
      end
    end else if (seed_we) begin
      seed_q[seed_sel] <= seed_i;
    end
  end

  // H3 hash: XOR tree over the seed words selected by key bits
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      lv0[i] = key_i[i] ? seed_q[i] : '0;
    end
    for (int i = 0; i < 16; i++) begin
      lv1[i] = lv0[2*i] ^ lv0[2*i+1];
    end
    for (int i = 0; i < 8; i++) begin
      lv2[i] = lv1[2*i] ^ lv1[2*i+1];
    end
    for (int i = 0; i < 4; i++) begin
      lv3[i] = lv2[2*i] ^ lv2[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      lv4[i] = lv3[2*i] ^ lv3[2*i+1];
    end
    hash = lv4[0] ^ lv4[1];
  end

  // Stage one: capture hashed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (f1_free) begin
      f1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_mode_q <= mode_i;
      f1_hash_q <= hash;
      f1_slot_q <= slot_i;
    end
  end

  // Classify: split the hash into bucket and remainder, or wrap the read index
  assign shamt    = BW'(IW) - bucket_bits_i;
  assign top_bits = f1_hash_q[HW-1 -: IW];
  assign idx_mask = {IW{1'b1}} >> shamt;

  always_comb begin
    f2_op_d   = hll_pkg::OP_NONE;
    f2_idx_d  = '0;
    f2_rest_d = '0;
    unique case (f1_mode_q)
      hll_pkg::MODE_UPDATE: begin
        f2_op_d   = hll_pkg::OP_UPDATE;
        f2_idx_d  = top_bits >> shamt;
        f2_rest_d = f1_hash_q << bucket_bits_i;
      end
      hll_pkg::MODE_READ: begin
        f2_op_d  = hll_pkg::OP_READ;
        f2_idx_d = f1_slot_q & idx_mask;
      end
      default: begin
        f2_op_d = hll_pkg::OP_NONE;
      end
    endcase
  end

  // Stage two: hold classified item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (f2_free) begin
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_adv) begin
      f2_op_q   <= f2_op_d;
      f2_idx_q  <= f2_idx_d;
      f2_rest_q <= f2_rest_d;
    end
  end

  // Rank: leading zeros of the remainder plus one; empty remainder counts its full width
  assign zeros = (f2_rest_q == '0) ? (RW'(HW) - RW'(bucket_bits_i)) : lzc32(f2_rest_q);
  assign rank  = zeros + RW'(1);

  assign push_valid_o    = f2_valid_q;
  assign push_job_o.op   = f2_op_q;
  assign push_job_o.rank = (f2_op_q == hll_pkg::OP_UPDATE) ? rank : '0;
  assign push_idx_o      = f2_idx_q;

endmodule

>>> design/hll_fifo.sv
// Short queue that decouples the front end from the bucket store back end.
// Depends on nothing beyond its parameters; used by the top level.
module hll_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // Store incoming item
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue occupancy above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push without pop did not grow queue");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("pop without push did not shrink queue");

endmodule

>>> design/hll_back.sv
// Back end: read-modify-write of the bucket store, empty-bucket count, output register.
// Depends on hll_pkg; takes jobs from hll_fifo.
module hll_back #(
  parameter int IW = 10,
  parameter int BW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [BW-1:0]              bucket_bits_i,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  hll_pkg::job_t              pop_job_i,
  input  logic [IW-1:0]              pop_idx_i,
  output logic                       clearing_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [IW-1:0]              out_idx_o,
  output logic [hll_pkg::RANK_W-1:0] out_rank_o,
  output logic                       out_raised_o,
  output logic [IW:0]                out_empty_o
);

  localparam int DEPTH = 1 << IW;
  localparam int RW    = hll_pkg::RANK_W;

  logic [RW-1:0]  bucket_mem_q [DEPTH];

  logic           clr_active_q;
  logic [IW-1:0]  clr_cnt_q;

  logic           pop;
  logic           b2_valid_q;
  hll_pkg::job_t  b2_job_q;
  logic [IW-1:0]  b2_idx_q;
  logic [RW-1:0]  rd_q;
  logic           b2_adv;
  logic           b2_free;

  logic           fwd_valid_q;
  logic [IW-1:0]  fwd_addr_q;
  logic [RW-1:0]  fwd_data_q;

  logic [RW-1:0]  old_val;
  logic           raise;
  logic           wr_en;

  logic [IW:0]    filled_q;
  logic [IW:0]    filled_d;
  logic [IW:0]    bucket_cnt;
  logic [IW:0]    empty_d;

  logic           out_valid_q;
  logic           out_free;
  logic [IW-1:0]  out_idx_q;
  logic [RW-1:0]  out_rank_q;
  logic           out_raised_q;
  logic [IW:0]    out_empty_q;
  logic [IW-1:0]  out_idx_d;
  logic [RW-1:0]  out_rank_d;

  // Flow control
  assign out_free    = !out_valid_q || out_ready_i;
  assign b2_adv      = b2_valid_q && out_free;
  assign b2_free     = !b2_valid_q || b2_adv;
  assign pop_ready_o = b2_free && !clr_active_q;
  assign pop         = pop_valid_i && pop_ready_o;
  assign clearing_o  = clr_active_q;

  // Sweep the store to zero after reset and after a bucket_bits write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (cfg_we_i) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      if (clr_cnt_q == IW'(DEPTH - 1)) begin
        clr_active_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + IW'(1);
    end
  end

  // Store write port
  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      bucket_mem_q[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      bucket_mem_q[b2_idx_q] <= b2_job_q.rank;
    end
  end

  // Store read port, registered
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q <= bucket_mem_q[pop_idx_i];
    end
  end

  // Job under update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else if (b2_free) begin
      b2_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b2_job_q <= pop_job_i;
      b2_idx_q <= pop_idx_i;
    end
  end

  // Remember the last write so a read issued on the same edge sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (clr_active_q) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= b2_idx_q;
      fwd_data_q <= b2_job_q.rank;
    end
  end

  assign old_val = (fwd_valid_q && (fwd_addr_q == b2_idx_q)) ? fwd_data_q : rd_q;
  assign raise   = (b2_job_q.op == hll_pkg::OP_UPDATE) && (b2_job_q.rank > old_val);
  assign wr_en   = b2_adv && raise;

  // Count filled buckets; empty count follows from the bucket count
  always_comb begin
    filled_d = filled_q;
    if (wr_en && (old_val == '0)) begin
      filled_d = filled_q + (IW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (cfg_we_i) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

  assign bucket_cnt = (IW+1)'(1) << bucket_bits_i;
  assign empty_d    = (filled_d >= bucket_cnt) ? '0 : bucket_cnt - filled_d;

  // Result fields by job kind
  always_comb begin
    out_idx_d  = '0;
    out_rank_d = '0;
    unique case (b2_job_q.op)
      hll_pkg::OP_UPDATE: begin
        out_idx_d  = b2_idx_q;
        out_rank_d = b2_job_q.rank;
      end
      hll_pkg::OP_READ: begin
        out_idx_d  = b2_idx_q;
        out_rank_d = old_val;
      end
      default: begin
        out_idx_d  = '0;
        out_rank_d = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_adv) begin
      out_idx_q    <= out_idx_d;
      out_rank_q   <= out_rank_d;
      out_raised_q <= raise;
      out_empty_q  <= empty_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_idx_o    = out_idx_q;
  assign out_rank_o   = out_rank_q;
  assign out_raised_o = out_raised_q;
  assign out_empty_o  = out_empty_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !pop)
    else $error("job taken during store clear");

  a_fill_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (old_val == '0) && !cfg_we_i) |=> (filled_q == $past(filled_q) + (IW+1)'(1)))
    else $error("first write to empty bucket not counted");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (clr_active_q && (filled_q == '0)))
    else $error("bucket_bits write did not start clear");

endmodule

>>> design/hyperloglog_register_update_top.sv
// Top level of the cardinality-sketch register update block.
// Depends on hll_pkg, hll_front, hll_fifo and hll_back.
//
// Usage:
//   Input stream (s_axis): tuser carries the item kind (update with key,
//   load seed word, read bucket, no-op); tdata carries key, slot index and
//   seed word. Output stream (m_axis): one result item per input item, in
//   order, with bucket index, rank, raised flag and empty-bucket count.
//   Config: cfg_we_i writes bucket_bits (log2 of bucket count) from
//   cfg_wdata_i; write only while the block is idle. A write clears the
//   bucket store and the fill count; seed words are kept.
// Pipeline: an item passes the hash stage, classify stage, queue, store
//   read-modify-write, then output register.
// Throughput: one item per cycle when no stall or store sweep holds it; the bucket
//   store read and write ports are used once per item and back-to-back hits on one bucket are forwarded.
// Reset: bucket_bits returns to 10, seed words clear to zero, and the store
//   is swept to zero over all 2^MAX_BUCKET_BITS entries (1024 by default) with
//   s_axis_tready low; a bucket_bits write starts the same sweep.
// Stall: when m_axis_tready is low the output register holds, the back end
//   stops and the queue and front stages fill before s_axis_tready drops.
module hyperloglog_register_update_top #(
  parameter int MAX_BUCKET_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hll_pkg::CFG_W-1:0] cfg_wdata_i,   // bucket_bits
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // key [31:0], slot_index, seed_word, zero fill
  input  logic [((64 + MAX_BUCKET_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic [hll_pkg::MODE_W-1:0] s_axis_tuser,  // mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // bucket_index, rank_value, bucket_raised, empty_buckets, zero fill
  output logic [((2 * MAX_BUCKET_BITS + 8 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int IW     = MAX_BUCKET_BITS;
  localparam int BW     = $clog2(MAX_BUCKET_BITS + 1);
  localparam int RW     = hll_pkg::RANK_W;
  localparam int HW     = hll_pkg::HASH_W;
  localparam int ENTRY_W = $bits(hll_pkg::job_t) + IW;

  logic [hll_pkg::CFG_W-1:0] bucket_bits_q;
  logic [BW-1:0]             eff_bits;

  logic                      push_valid;
  logic                      push_ready;
  hll_pkg::job_t             push_job;
  logic [IW-1:0]             push_idx;
  logic                      pop_valid;
  logic                      pop_ready;
  logic [ENTRY_W-1:0]        pop_data;
  hll_pkg::job_t             pop_job;
  logic [IW-1:0]             pop_idx;
  logic                      clearing;

  logic [IW-1:0]             out_idx;
  logic [RW-1:0]             out_rank;
  logic                      out_raised;
  logic [IW:0]               out_empty;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_bits_q <= hll_pkg::BUCKET_BITS_RST;
    end else if (cfg_we_i) begin
      bucket_bits_q <= cfg_wdata_i;
    end
  end

  // Saturate bucket_bits into 1..MAX_BUCKET_BITS
  always_comb begin
    priority if (bucket_bits_q == '0) begin
      eff_bits = BW'(1);
    end else if (32'(bucket_bits_q) > 32'(MAX_BUCKET_BITS)) begin
      eff_bits = BW'(MAX_BUCKET_BITS);
    end else begin
      eff_bits = BW'(bucket_bits_q);
    end
  end

  hll_front #(
    .IW (IW),
    .BW (BW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .mode_i        (hll_pkg::mode_e'(s_axis_tuser)),
    .key_i         (s_axis_tdata[hll_pkg::KEY_W-1:0]),
    .slot_i        (s_axis_tdata[hll_pkg::KEY_W +: IW]),
    .seed_i        (s_axis_tdata[hll_pkg::KEY_W + IW +: HW]),
    .bucket_bits_i (eff_bits),
    .hold_i        (clearing),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_job_o    (push_job),
    .push_idx_o    (push_idx)
  );

  hll_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (hll_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_job, push_idx}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_job = hll_pkg::job_t'(pop_data[ENTRY_W-1:IW]);
  assign pop_idx = pop_data[IW-1:0];

  hll_back #(
    .IW (IW),
    .BW (BW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .bucket_bits_i (eff_bits),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_job_i     (pop_job),
    .pop_idx_i     (pop_idx),
    .clearing_o    (clearing),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_idx_o     (out_idx),
    .out_rank_o    (out_rank),
    .out_raised_o  (out_raised),
    .out_empty_o   (out_empty)
  );

  // Pack result fields, lowest first
  always_comb begin
    m_axis_tdata                     = '0;
    m_axis_tdata[IW-1:0]             = out_idx;
    m_axis_tdata[IW +: RW]           = out_rank;
    m_axis_tdata[IW + RW]            = out_raised;
    m_axis_tdata[IW + RW + 1 +: IW + 1] = out_empty;
  end

endmodule

>>> bench/hll_sketch_checker.sv
// Watches the streams and config port of hyperloglog_register_update_top,
// keeps its own copy of the sketch state and compares every result item.
// Depends on hll_pkg for the item kinds and field widths.
module hll_sketch_checker #(
  parameter int MAX_BB = 10,
  parameter int S_W    = 80,
  parameter int M_W    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hll_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [S_W-1:0]                s_tdata_i,
  input  logic [hll_pkg::MODE_W-1:0]    s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [M_W-1:0]                m_tdata_i,
  output int unsigned                   pending_o,
  output int unsigned                   mismatches_o
);

  localparam int BUCKETS = 1 << MAX_BB;

  typedef struct packed {
    logic [MAX_BB-1:0]          bucket;
    logic [hll_pkg::RANK_W-1:0] rank;
    logic                       raised;
    logic [MAX_BB:0]            empty;
  } sketch_result_t;

  // Shadow state of the sketch
  logic [hll_pkg::CFG_W-1:0]   shadow_bits;
  logic [hll_pkg::RANK_W-1:0]  shadow_buckets [BUCKETS];
  logic [hll_pkg::HASH_W-1:0]  shadow_seeds [hll_pkg::SEED_COUNT];
  int unsigned                 shadow_filled;
  sketch_result_t              sketch_results_q [$];
  int unsigned                 mismatch_count;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned active_bits();
    int unsigned b;
    b = 32'(shadow_bits);
    if (b < 1) b = 1;
    if (b > MAX_BB) b = MAX_BB;
    return b;
  endfunction

  function automatic void clear_buckets();
    foreach (shadow_buckets[i]) shadow_buckets[i] = '0;
    shadow_filled = 0;
  endfunction

  // Apply one item to the shadow sketch and return the result it yields
  function automatic sketch_result_t apply_sketch_item(hll_pkg::mode_e kind,
                                                      logic [hll_pkg::KEY_W-1:0] key,
                                                      logic [MAX_BB-1:0] slot,
                                                      logic [hll_pkg::HASH_W-1:0] seed);
    sketch_result_t res;
    logic [hll_pkg::HASH_W-1:0] hash;
    int unsigned b, rest_bits, zeros, idx, rank;
    res = '0;
    b = active_bits();
    case (kind)
      hll_pkg::MODE_UPDATE: begin
        hash = '0;
        for (int i = 0; i < hll_pkg::KEY_W; i++) begin
          if (key[i]) hash ^= shadow_seeds[i];
        end
        rest_bits = hll_pkg::HASH_W - b;
        zeros = 0;
        while (zeros < rest_bits && hash[rest_bits - 1 - zeros] == 1'b0) zeros++;
        idx = (hash >> rest_bits) & ((1 << b) - 1);
        rank = zeros + 1;
        res.bucket = idx[MAX_BB-1:0];
        res.rank = rank[hll_pkg::RANK_W-1:0];
        if (rank > shadow_buckets[idx]) begin
          if (shadow_buckets[idx] == '0) shadow_filled++;
          shadow_buckets[idx] = rank[hll_pkg::RANK_W-1:0];
          res.raised = 1'b1;
        end
      end
      hll_pkg::MODE_SEED: begin
        if (32'(slot) < hll_pkg::SEED_COUNT) shadow_seeds[slot] = seed;
      end
      hll_pkg::MODE_READ: begin
        idx = 32'(slot) & ((1 << b) - 1);
        res.bucket = idx[MAX_BB-1:0];
        res.rank = shadow_buckets[idx];
      end
      default: ;
    endcase
    res.empty = (MAX_BB+1)'((1 << b) - shadow_filled);
    return res;
  endfunction

  // Check results, follow config writes, predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin : watch
    sketch_result_t got, want;
    int unsigned pushed, popped;
    if (!rst_ni) begin
      shadow_bits = hll_pkg::BUCKET_BITS_RST;
      foreach (shadow_seeds[i]) shadow_seeds[i] = '0;
      clear_buckets();
      sketch_results_q.delete();
      pending_o <= 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (m_tvalid_i && m_tready_i) begin
        got.bucket = m_tdata_i[0 +: MAX_BB];
        got.rank   = m_tdata_i[MAX_BB +: hll_pkg::RANK_W];
        got.raised = m_tdata_i[MAX_BB + hll_pkg::RANK_W];
        got.empty  = m_tdata_i[MAX_BB + hll_pkg::RANK_W + 1 +: MAX_BB + 1];
        if (sketch_results_q.size() == 0) begin
          report_mismatch($sformatf("result item with none expected, data %h", m_tdata_i));
        end else begin
          want = sketch_results_q.pop_front();
          popped = 1;
          if (got.bucket != want.bucket)
            report_mismatch($sformatf("bucket_index got %0d expected %0d",
                                      got.bucket, want.bucket));
          if (got.rank != want.rank)
            report_mismatch($sformatf("rank_value got %0d expected %0d",
                                      got.rank, want.rank));
          if (got.raised != want.raised)
            report_mismatch($sformatf("bucket_raised got %0d expected %0d",
                                      got.raised, want.raised));
          if (got.empty != want.empty)
            report_mismatch($sformatf("empty_buckets got %0d expected %0d",
                                      got.empty, want.empty));
        end
      end
      // A bucket_bits write wipes the store but keeps the seeds
      if (cfg_we_i) begin
        shadow_bits = cfg_wdata_i;
        clear_buckets();
      end
      if (s_tvalid_i && s_tready_i) begin
        sketch_results_q.push_back(apply_sketch_item(
            hll_pkg::mode_e'(s_tuser_i),
            s_tdata_i[0 +: hll_pkg::KEY_W],
            s_tdata_i[hll_pkg::KEY_W +: MAX_BB],
            s_tdata_i[hll_pkg::KEY_W + MAX_BB +: hll_pkg::HASH_W]));
        pushed = 1;
      end
      pending_o <= pending_o + pushed - popped;
    end
  end

endmodule

>>> bench/tb.sv
// Testbench top for hyperloglog_register_update_top: clock, reset, directed
// and random item streams, config writes and the final verdict.
// Depends on hll_pkg and hll_sketch_checker.
module tb;

  localparam int MAX_BB = 10;
  localparam int S_W = ((64 + MAX_BB + 7) / 8) * 8;
  localparam int M_W = ((2 * MAX_BB + 8 + 7) / 8) * 8;
  localparam int PHASE_ITEMS = 170;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [hll_pkg::CFG_W-1:0]   cfg_wdata_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [S_W-1:0]              s_axis_tdata;
  logic [hll_pkg::MODE_W-1:0]  s_axis_tuser;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [M_W-1:0]              m_axis_tdata;

  int unsigned                 pending_results;
  int unsigned                 mismatches;
  int unsigned                 src_idle_pct;
  int unsigned                 sink_idle_pct;
  logic [hll_pkg::KEY_W-1:0]   last_key;

  hyperloglog_register_update_top #(
    .MAX_BUCKET_BITS(MAX_BB)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  hll_sketch_checker #(
    .MAX_BB(MAX_BB),
    .S_W   (S_W),
    .M_W   (M_W)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .pending_o   (pending_results),
    .mismatches_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the result stream at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Offer one item, idling at random first, and hold until it is taken
  task automatic send_item(input hll_pkg::mode_e kind,
                           input logic [hll_pkg::KEY_W-1:0] key,
                           input logic [MAX_BB-1:0] slot,
                           input logic [hll_pkg::HASH_W-1:0] seed);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= S_W'({seed, slot, key});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic write_bucket_bits(input logic [hll_pkg::CFG_W-1:0] bits);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bits;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly updates with a mix of fresh, repeated and sparse keys
  task automatic send_random_item();
    int unsigned pick;
    logic [hll_pkg::KEY_W-1:0] key;
    logic [MAX_BB-1:0] slot;
    pick = $urandom_range(99);
    if (pick < 65) begin
      case ($urandom_range(6))
        0:       key = last_key;
        1:       key = 32'd1 << $urandom_range(31);
        2:       key = '0;
        default: key = $urandom;
      endcase
      last_key = key;
      send_item(hll_pkg::MODE_UPDATE, key, MAX_BB'($urandom), $urandom);
    end else if (pick < 80) begin
      send_item(hll_pkg::MODE_READ, $urandom, MAX_BB'($urandom_range(1023)), $urandom);
    end else if (pick < 92) begin
      slot = ($urandom_range(9) == 0) ? MAX_BB'($urandom_range(1023))
                                      : MAX_BB'($urandom_range(hll_pkg::SEED_COUNT - 1));
      send_item(hll_pkg::MODE_SEED, $urandom, slot, $urandom);
    end else begin
      send_item(hll_pkg::MODE_NOP, $urandom, MAX_BB'($urandom_range(1023)), $urandom);
    end
  endtask

  initial begin : stimulus
    logic [hll_pkg::CFG_W-1:0] phase_bits [6];
    phase_bits = '{4'd10, 4'd3, 4'd1, 4'd7, 4'd2, 4'd9};
    src_idle_pct  = 14;
    sink_idle_pct = 57;
    last_key      = '0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= hll_pkg::MODE_NOP;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty store, all-zero hash, seed edges and out-of-range slots
    send_item(hll_pkg::MODE_READ,   '0, '0, '0);
    send_item(hll_pkg::MODE_UPDATE, '0, '0, '0);
    send_item(hll_pkg::MODE_UPDATE, '0, '0, '0);
    send_item(hll_pkg::MODE_NOP,    '1, '1, '1);
    send_item(hll_pkg::MODE_SEED,   '0, 10'd0,  32'hffff_ffff);
    send_item(hll_pkg::MODE_SEED,   '0, 10'd31, 32'h0000_0001);
    send_item(hll_pkg::MODE_SEED,   '0, 10'd32, 32'hdead_beef);
    send_item(hll_pkg::MODE_SEED,   '0, '1,     32'hffff_ffff);
    send_item(hll_pkg::MODE_UPDATE, 32'h0000_0001, '0, '0);
    send_item(hll_pkg::MODE_UPDATE, 32'h8000_0000, '0, '0);
    send_item(hll_pkg::MODE_UPDATE, '1, '0, '0);
    send_item(hll_pkg::MODE_READ,   '0, '1, '0);
    send_item(hll_pkg::MODE_READ,   '0, '0, '0);

    // Zero acts as one bucket bit: reads wrap, ranks reach full width
    write_bucket_bits(4'd0);
    send_item(hll_pkg::MODE_READ,   '0, '1, '0);
    send_item(hll_pkg::MODE_UPDATE, '0, '0, '0);
    send_item(hll_pkg::MODE_UPDATE, 32'h0000_0001, '0, '0);
    send_item(hll_pkg::MODE_READ,   '0, 10'd2, '0);
    send_item(hll_pkg::MODE_NOP,    '0, '0, '0);

    // Oversized value saturates to the widest setting
    write_bucket_bits(4'd15);
    send_item(hll_pkg::MODE_UPDATE, 32'h8000_0001, '0, '0);
    send_item(hll_pkg::MODE_READ,   '0, 10'd1023, '0);
    send_item(hll_pkg::MODE_UPDATE, 32'h8000_0000, '0, '0);

    // Random phases, each with its own bucket width; the idling profile changes at phases 2 and 4
    for (int p = 0; p < 6; p++) begin
      write_bucket_bits(phase_bits[p]);
      if (p == 2) begin
        src_idle_pct  = 57;
        sink_idle_pct = 14;
      end else if (p == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (p == 0) begin
        for (int s = 0; s < hll_pkg::SEED_COUNT; s++) begin
          send_item(hll_pkg::MODE_SEED, $urandom, MAX_BB'(s), $urandom);
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
